>>> hdl/sdso_pkg.sv
// Shared types, constants and the quarter-wave sine table for the swept dual sine oscillator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sdso_pkg;

  localparam int PHASE_BITS         = 32;
  localparam int SINE_TABLE_ENTRIES = 1024;
  localparam int CONTROL_BITS       = 16;

  localparam int QUARTER_LEN = SINE_TABLE_ENTRIES / 4;
  localparam int IDX_W       = $clog2(SINE_TABLE_ENTRIES);
  localparam int QB          = IDX_W - 2;
  localparam int TIDX_W      = QB + 1;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int INC_W      = 32;
  localparam int GAIN_W     = 15;
  localparam int SINE_W     = 16;
  localparam int TONE_W     = 32;
  localparam int MUL_W      = 33;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int ROOT_W     = 31;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int OUT_W      = 18;

  localparam int IN_TDATA_W  = ((CONTROL_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  localparam logic [INC_W-1:0]      FSI_RST   = 32'd97391548;
  localparam logic [INC_W-1:0]      TINC_RST  = 32'd42852281;
  localparam logic [GAIN_W-1:0]     AMP_RST   = 15'd32702;
  localparam logic [GAIN_W-1:0]     DEPTH_RST = 15'd32440;
  localparam logic [PHASE_BITS-1:0] STEP_RST  = PHASE_BITS'(64'd42852281);

  localparam int OFFSET_Q14   = 11585;
  localparam int ROUND_SHIFT  = 46;
  localparam longint HALF_PI_Q30 = 64'd1686629713;

  localparam longint TaylorDiv [1:8] = '{6, 20, 42, 72, 110, 156, 210, 272};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SWEEP_FSI   = 8'd0,
    REG_TONE_INC    = 8'd1,
    REG_SWEEP_AMP   = 8'd2,
    REG_TONE_DEPTH  = 8'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MUL_STEP,
    MUL_INNER,
    MUL_TONE,
    MUL_OUT
  } mul_sel_t;

  typedef enum logic {
    SINE_SWEEP,
    SINE_TONE
  } sine_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STEP_MUL,
    ST_STEP_WR,
    ST_SIN_SWEEP,
    ST_INNER_MUL,
    ST_SIN_TONE,
    ST_TONE_MUL,
    ST_TONE_WR,
    ST_SQRT_WAIT,
    ST_OUT_MUL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic      in_load;
    logic      mul_en;
    mul_sel_t  mul_sel;
    logic      step_load;
    logic      sine_load;
    sine_sel_t sine_sel;
    logic      sqrt_start;
    logic      tone_load;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic ctl_valid;
    logic sqrt_busy;
  } stat_t;

  typedef logic [GAIN_W-1:0] qtab_t [0:QUARTER_LEN];

  // Q30 Taylor series for sin over the first quadrant, scaled to unsigned Q0.15
  function automatic qtab_t build_qtab();
    qtab_t  t;
    longint x;
    longint x2;
    longint term;
    longint sum;
    longint v;
    for (int k = 0; k <= QUARTER_LEN; k++) begin
      x    = (longint'(k) * HALF_PI_Q30) / QUARTER_LEN;
      x2   = (x * x) >>> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >>> 30) / TaylorDiv[n];
        if (n % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (sum * 32767 + (64'sd1 <<< 29)) >>> 30;
      if (v > 32767) begin
        v = 32767;
      end
      t[k] = GAIN_W'(v);
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();

endpackage

>>> hdl/sdso_isqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on sdso_pkg for widths.
`timescale 1ns / 1ps

module sdso_isqrt
  import sdso_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              busy,
  output logic [ROOT_W-1:0] root
);

  localparam int CNT_W = $clog2(ROOT_W);
  localparam int REM_W = ROOT_W + 2;
  localparam int SH_W  = REM_W + 2;

  logic              busy_r, busy_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [RAD_W-1:0]  rad_r, rad_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;

  logic [SH_W-1:0] rem_sh;
  logic [SH_W-1:0] trial;
  logic            ge;

  always_comb begin
    rem_sh   = {rem_r, rad_r[RAD_W-1 -: 2]};
    trial    = SH_W'({root_r, 2'b01});
    ge       = (rem_sh >= trial);
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rad_nxt  = {rad_r[RAD_W-3:0], 2'b00};
      rem_nxt  = ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root_nxt = {root_r[ROOT_W-2:0], ge};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(ROOT_W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

>>> hdl/sdso_datapath.sv
// Datapath: configuration registers, phase accumulators, sine lookup, shared multiplier,
// square root unit and output rounding. Depends on sdso_pkg and sdso_isqrt.
`timescale 1ns / 1ps

module sdso_datapath
  import sdso_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_flag,
  input  logic [CONTROL_BITS-1:0] in_sample,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  output logic [OUT_W-1:0]      out_data
);

  localparam int RND_W = PROD_W - ROUND_SHIFT;
  localparam int DIF_W = RND_W + 1;

  logic [INC_W-1:0]  fsi_r, tinc_r;
  logic [GAIN_W-1:0] amp_r, depth_r;

  logic [PHASE_BITS-1:0] sweep_phase_r, tone_phase_r, sweep_step_r;

  logic                    ctl_valid_r;
  logic [CONTROL_BITS-1:0] ctl_r;
  logic signed [SINE_W-1:0] sine_r, sine_nxt;
  logic signed [TONE_W-1:0] tone_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [OUT_W-1:0]         out_r, out_nxt;

  logic signed [MUL_W-1:0] mul_a, mul_b;

  logic [PHASE_BITS-1:0] phase_sel;
  logic [IDX_W-1:0]      idx;
  logic [1:0]            quad;
  logic [TIDX_W-1:0]     tidx;
  logic [GAIN_W-1:0]     tval;

  logic signed [MUL_W-1:0] inner_s;
  logic [ROOT_W-1:0]       inner_u;
  logic [RAD_W-1:0]        radicand;
  logic [ROOT_W-1:0]       root;
  logic                    sqrt_busy;

  logic signed [PROD_W-1:0] rsum;
  logic signed [RND_W-1:0]  rnd;
  logic signed [DIF_W-1:0]  diff;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsi_r   <= FSI_RST;
      tinc_r  <= TINC_RST;
      amp_r   <= AMP_RST;
      depth_r <= DEPTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SWEEP_FSI:  fsi_r   <= INC_W'(cfg_data);
        REG_TONE_INC:   tinc_r  <= INC_W'(cfg_data);
        REG_SWEEP_AMP:  amp_r   <= cfg_data[GAIN_W-1:0];
        REG_TONE_DEPTH: depth_r <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // sine lookup, folded by quadrant
  always_comb begin
    phase_sel = (cmd.sine_sel == SINE_TONE) ? tone_phase_r : sweep_phase_r;
    idx       = phase_sel[PHASE_BITS-1 -: IDX_W];
    quad      = idx[IDX_W-1 -: 2];
    tidx      = quad[0] ? TIDX_W'(QUARTER_LEN) - {1'b0, idx[QB-1:0]} : {1'b0, idx[QB-1:0]};
    tval      = QTAB[tidx];
    sine_nxt  = quad[1] ? -$signed({1'b0, tval}) : $signed({1'b0, tval});
  end

  // shared multiplier operands
  always_comb begin
    case (cmd.mul_sel)
      MUL_STEP: begin
        mul_a = MUL_W'(fsi_r);
        mul_b = MUL_W'(ctl_r);
      end
      MUL_INNER: begin
        mul_a = MUL_W'(amp_r);
        mul_b = MUL_W'(sine_r);
      end
      MUL_TONE: begin
        mul_a = MUL_W'(depth_r);
        mul_b = MUL_W'(sine_r);
      end
      MUL_OUT: begin
        mul_a = MUL_W'(root);
        mul_b = MUL_W'(tone_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // 1 + amplitude*sin, Q2.30, then shifted up for a Q1.30 root
  always_comb begin
    inner_s  = $signed(prod_r[MUL_W-1:0]) + $signed(MUL_W'(64'd1 << 30));
    inner_u  = inner_s[MUL_W-1] ? '0 : inner_s[ROOT_W-1:0];
    radicand = RAD_W'({inner_u, 30'b0});
  end

  sdso_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (radicand),
    .busy     (sqrt_busy),
    .root     (root)
  );

  // round half up to Q.14, subtract from offset, saturate
  always_comb begin
    rsum = prod_r + $signed(PROD_W'(64'd1 << (ROUND_SHIFT - 1)));
    rnd  = rsum[PROD_W-1:ROUND_SHIFT];
    diff = $signed(DIF_W'(OFFSET_Q14)) - DIF_W'(rnd);
    if (diff < -$signed(DIF_W'(64'd1 << (OUT_W - 1)))) begin
      out_nxt = {1'b1, {(OUT_W-1){1'b0}}};
    end else if (diff > $signed(DIF_W'((64'd1 << (OUT_W - 1)) - 1))) begin
      out_nxt = {1'b0, {(OUT_W-1){1'b1}}};
    end else begin
      out_nxt = diff[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_phase_r <= '0;
      tone_phase_r  <= '0;
      sweep_step_r  <= STEP_RST;
      ctl_valid_r   <= 1'b0;
    end else begin
      if (cmd.in_load) begin
        ctl_valid_r <= in_flag;
      end
      if (cmd.step_load) begin
        sweep_step_r <= PHASE_BITS'(prod_r >> CONTROL_BITS);
      end
      if (cmd.out_load) begin
        sweep_phase_r <= sweep_phase_r + sweep_step_r;
        tone_phase_r  <= tone_phase_r + PHASE_BITS'(tinc_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      ctl_r <= in_sample;
    end
    if (cmd.sine_load) begin
      sine_r <= sine_nxt;
    end
    if (cmd.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.tone_load) begin
      tone_r <= prod_r[TONE_W-1:0];
    end
    if (cmd.out_load) begin
      out_r <= out_nxt;
    end
  end

  assign stat.ctl_valid = ctl_valid_r;
  assign stat.sqrt_busy = sqrt_busy;
  assign out_data       = out_r;

endmodule

>>> hdl/sdso_ctrl.sv
// Sequencer for one frame: control step update, two sine lookups, shared multiplier,
// square root wait and output hand-off. Depends on sdso_pkg.
`timescale 1ns / 1ps

module sdso_ctrl
  import sdso_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  output logic  out_tvalid,
  input  logic  out_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mul_sel  = MUL_STEP;
    cmd.sine_sel = SINE_SWEEP;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.in_load = 1'b1;
          state_nxt   = ST_STEP_MUL;
        end
      end
      ST_STEP_MUL: begin
        if (stat.ctl_valid) begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MUL_STEP;
          state_nxt   = ST_STEP_WR;
        end else begin
          state_nxt = ST_SIN_SWEEP;
        end
      end
      ST_STEP_WR: begin
        cmd.step_load = 1'b1;
        state_nxt     = ST_SIN_SWEEP;
      end
      ST_SIN_SWEEP: begin
        cmd.sine_load = 1'b1;
        cmd.sine_sel  = SINE_SWEEP;
        state_nxt     = ST_INNER_MUL;
      end
      ST_INNER_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_INNER;
        state_nxt   = ST_SIN_TONE;
      end
      ST_SIN_TONE: begin
        cmd.sine_load  = 1'b1;
        cmd.sine_sel   = SINE_TONE;
        cmd.sqrt_start = 1'b1;
        state_nxt      = ST_TONE_MUL;
      end
      ST_TONE_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_TONE;
        state_nxt   = ST_TONE_WR;
      end
      ST_TONE_WR: begin
        cmd.tone_load = 1'b1;
        state_nxt     = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: begin
        if (!stat.sqrt_busy) begin
          state_nxt = ST_OUT_MUL;
        end
      end
      ST_OUT_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_OUT;
        state_nxt   = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

  a_start_idle_root: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sqrt_start |-> !stat.sqrt_busy)
    else $error("square root restarted while busy");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("pending result overwritten");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second transaction accepted while busy");

  a_result_per_item: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (out_tvalid && state_r == ST_IDLE))
    else $error("result load did not complete the frame");

endmodule

>>> hdl/sqrt_shaped_dual_sine_oscillator.sv
// Top level of the square-root shaped dual sine oscillator.
// Depends on sdso_pkg, sdso_ctrl and sdso_datapath.
`timescale 1ns / 1ps

// One input transaction per audio frame gives one output sample:
// offset - sqrt(1 + amplitude*sin(sweep)) * depth*sin(tone), signed Q4.14. A frame whose
// tuser flag is set loads a new sweep step from the control sample; otherwise the step holds.
// Frames are processed one at a time: the next frame is accepted only after the last result
// is loaded and the sequencer is back in idle. The frame time is set by the bit-serial square
// root; all products go through one shared 33x33 multiplier. A finished sample waits in the
// output register while the next frame is accepted. Configuration writes are always taken
// and should only be issued between frames.
module sqrt_shaped_dual_sine_oscillator
  import sdso_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] control_sample
  input  logic                   in_tuser,   // [0] control_valid
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [17:0] audio_out, rest zero
);

  cmd_t             cmd;
  stat_t            stat;
  logic [OUT_W-1:0] out_data;

  assign cfg_ready = 1'b1;

  sdso_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  sdso_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_flag   (in_tuser),
    .in_sample (in_tdata[CONTROL_BITS-1:0]),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

  assign out_tdata = OUT_TDATA_W'(out_data);

endmodule

>>> dv/tb_sqrt_shaped_dual_sine_oscillator.sv
// Self-checking testbench for the square-root shaped dual sine oscillator.
// Drives frames and register writes and checks every output sample against an internal predictor.
// Depends on sdso_pkg and sqrt_shaped_dual_sine_oscillator.
`timescale 1ns / 1ps

module tb_sqrt_shaped_dual_sine_oscillator;
  import sdso_pkg::*;

  localparam int  CYCLE_LIMIT = 1000000;
  localparam int  RANDOM_FRAMES = 1250;
  localparam logic [CFG_IDX_W-1:0] SPARE_REG_LO = CFG_IDX_W'(REG_TONE_DEPTH) + 1'b1;
  localparam logic [CFG_IDX_W-1:0] SPARE_REG_HI = '1;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [15:0] control_sample
  logic                   in_tuser = 1'b0; // [0] control_valid
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [17:0] audio_out, rest zero

  // predictor state and register shadow
  logic [INC_W-1:0]      sh_fsi;
  logic [INC_W-1:0]      sh_tinc;
  logic [GAIN_W-1:0]     sh_amp;
  logic [GAIN_W-1:0]     sh_depth;
  logic [PHASE_BITS-1:0] sweep_phase;
  logic [PHASE_BITS-1:0] tone_phase;
  logic [PHASE_BITS-1:0] sweep_step;
  int                    quarter_sine [0:QUARTER_LEN];

  logic [OUT_W-1:0] pending_audio [$];
  int               err_count = 0;
  int               cycle_count = 0;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;

  sqrt_shaped_dual_sine_oscillator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // output checker
  always @(posedge clk) begin
    logic [OUT_TDATA_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_audio.size() == 0) begin
        $display("%0t unexpected output transaction: actual 0x%h", $time, out_tdata);
        err_count++;
      end else begin
        want = OUT_TDATA_W'(pending_audio.pop_front());
        if (out_tdata !== want) begin
          $display("%0t audio_out mismatch: expected %0d (0x%h) actual %0d (0x%h)", $time,
                   $signed(want[OUT_W-1:0]), want, $signed(out_tdata[OUT_W-1:0]), out_tdata);
          err_count++;
        end
      end
    end
  end

  function automatic longint sine_at(input logic [PHASE_BITS-1:0] phase);
    logic [IDX_W-1:0] slot;
    logic [1:0]       quad;
    logic [QB-1:0]    offs;
    longint           mag;
    slot = phase[PHASE_BITS-1 -: IDX_W];
    quad = slot[IDX_W-1 -: 2];
    offs = slot[QB-1:0];
    mag  = quad[0] ? quarter_sine[QUARTER_LEN - int'(offs)] : quarter_sine[offs];
    return quad[1] ? -mag : mag;
  endfunction

  // works out the sample for one accepted frame and advances both phases
  task automatic advance_frame(input logic ctl_fresh, input logic [CONTROL_BITS-1:0] ctl);
    longint          amp_l;
    longint          depth_l;
    longint          inner;
    longint          tone;
    longint          prod;
    longint          res;
    longint unsigned rad;
    longint unsigned root;
    longint unsigned probe;
    if (ctl_fresh) begin
      sweep_step = PHASE_BITS'((64'(sh_fsi) * 64'(ctl)) >> CONTROL_BITS);
    end
    amp_l   = longint'(sh_amp);
    depth_l = longint'(sh_depth);
    inner = (64'sd1 <<< 30) + amp_l * sine_at(sweep_phase);
    if (inner < 0) begin
      inner = 0;
    end
    rad   = longint'(inner) << 30;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > rad) begin
      probe = probe >> 2;
    end
    while (probe != 0) begin
      if (rad >= root + probe) begin
        rad  = rad - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    tone = depth_l * sine_at(tone_phase);
    prod = longint'(root) * tone;
    res  = longint'(OFFSET_Q14) - ((prod + (64'sd1 <<< 45)) >>> 46);
    if (res < -131072) begin
      res = -131072;
    end
    if (res > 131071) begin
      res = 131071;
    end
    pending_audio.push_back(OUT_W'(res));
    sweep_phase = sweep_phase + sweep_step;
    tone_phase  = tone_phase + PHASE_BITS'(sh_tinc);
  endtask

  // called and returns at a falling edge
  task automatic send_frame(input logic ctl_fresh, input logic [CONTROL_BITS-1:0] ctl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      in_tdata  = IN_TDATA_W'($urandom);
      in_tuser  = 1'($urandom_range(1));
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = IN_TDATA_W'(ctl);
    in_tuser  = ctl_fresh;
    do @(posedge clk); while (!in_tready);
    advance_frame(ctl_fresh, ctl);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SWEEP_FSI:  sh_fsi = value[INC_W-1:0];
      REG_TONE_INC:   sh_tinc = value[INC_W-1:0];
      REG_SWEEP_AMP:  sh_amp = value[GAIN_W-1:0];
      REG_TONE_DEPTH: sh_depth = value[GAIN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_audio.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_value();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return CFG_DATA_W'($urandom_range(32767));
      default: return $urandom;
    endcase
  endfunction

  task automatic test_reset_state();
    repeat (3) send_frame(1'b0, CONTROL_BITS'($urandom));
  endtask

  task automatic test_control_extremes();
    send_frame(1'b1, 16'hFFFF);
    send_frame(1'b1, 16'h0000);
    send_frame(1'b1, 16'h8000);
    send_frame(1'b1, 16'hAAAA);
    send_frame(1'b1, 16'h5555);
    send_frame(1'b1, 16'h0001);
    send_frame(1'b0, 16'h1234);
  endtask

  task automatic test_register_extremes();
    wait_idle();
    write_reg(REG_SWEEP_FSI, '1);
    write_reg(REG_TONE_INC, '1);
    write_reg(REG_SWEEP_AMP, '1);
    write_reg(REG_TONE_DEPTH, '1);
    write_reg(SPARE_REG_LO, '0);
    write_reg(SPARE_REG_HI, '0);
    send_frame(1'b1, 16'hFFFF);
    repeat (4) send_frame(1'b0, CONTROL_BITS'($urandom));
    wait_idle();
    write_reg(REG_SWEEP_FSI, '0);
    write_reg(REG_TONE_INC, '0);
    write_reg(REG_SWEEP_AMP, '0);
    write_reg(REG_TONE_DEPTH, '0);
    send_frame(1'b1, 16'hFFFF);
    repeat (2) send_frame(1'b0, 16'h0000);
    wait_idle();
    write_reg(REG_SWEEP_FSI, FSI_RST);
    write_reg(REG_TONE_INC, 32'h4000_0000);
    write_reg(REG_SWEEP_AMP, 32'h0000_7FFF);
    write_reg(REG_TONE_DEPTH, 32'hFFFF_7FFF);
    send_frame(1'b1, 16'hFFFF);
    repeat (4) send_frame(1'b0, 16'h0000);
  endtask

  task automatic test_random_traffic(input int frames, input int s_pct, input int r_pct);
    logic [CONTROL_BITS-1:0] ctl;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int blk = 0; blk < 4; blk++) begin
      wait_idle();
      write_reg(REG_SWEEP_FSI, pick_value());
      write_reg(REG_TONE_INC, pick_value());
      write_reg(REG_SWEEP_AMP, pick_value());
      write_reg(REG_TONE_DEPTH, pick_value());
      if ($urandom_range(3) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(int'(SPARE_REG_HI), int'(SPARE_REG_LO))), $urandom);
      end
      for (int i = 0; i < frames / 4; i++) begin
        case ($urandom_range(9))
          0: ctl = '0;
          1: ctl = '1;
          default: ctl = CONTROL_BITS'($urandom);
        endcase
        send_frame($urandom_range(9) < 3, ctl);
      end
    end
  endtask

  initial begin
    longint x;
    longint x2;
    longint term;
    longint sum;
    longint v;
    for (int k = 0; k <= QUARTER_LEN; k++) begin
      x    = (longint'(k) * HALF_PI_Q30) / QUARTER_LEN;
      x2   = (x * x) >>> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >>> 30) / ((2 * n) * (2 * n + 1));
        sum  = (n % 2 == 1) ? sum - term : sum + term;
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (sum * 32767 + (64'sd1 <<< 29)) >>> 30;
      quarter_sine[k] = (v > 32767) ? 32767 : int'(v);
    end
    sh_fsi      = FSI_RST;
    sh_tinc     = TINC_RST;
    sh_amp      = AMP_RST;
    sh_depth    = DEPTH_RST;
    sweep_phase = '0;
    tone_phase  = '0;
    sweep_step  = STEP_RST;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_idle_pct = 17;
    recv_idle_pct = 45;
    test_reset_state();
    test_control_extremes();
    test_register_extremes();
    test_random_traffic(RANDOM_FRAMES / 3, 17, 45);
    test_random_traffic(RANDOM_FRAMES / 3, 45, 17);
    test_random_traffic(RANDOM_FRAMES - 2 * (RANDOM_FRAMES / 3), 0, 0);

    wait_idle();
    repeat (40) @(negedge clk);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/sdso_pkg.sv
hdl/sdso_isqrt.sv
hdl/sdso_datapath.sv
hdl/sdso_ctrl.sv
hdl/sqrt_shaped_dual_sine_oscillator.sv
dv/tb_sqrt_shaped_dual_sine_oscillator.sv
